/* src/b2s_pkg.sv */
// Shared constants and the quarter-wave sine table generator for the byte-to-sample mixer.
`default_nettype none
package b2s_pkg;

  localparam int unsigned HALF_PI_Q30 = 32'd1686629713;
  localparam int unsigned SINE_W      = 15;
  localparam int unsigned QUOT_W      = 17;
  localparam int unsigned ACC_W       = 48;
  localparam int unsigned FRAC_ONE    = 65536;

  typedef logic [SINE_W-1:0] sine_mag_t;

  // One quarter-wave entry: Q30 Taylor series of sin through x^15, rounded to Q15.
  function automatic sine_mag_t sine_entry(input int unsigned k, input int unsigned tb);
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    longint unsigned v;
    x    = (64'(k) * 64'(HALF_PI_Q30)) >> tb;
    term = x;
    sum  = longint'(x);
    term = ((((term * x) >> 30) * x) >> 30) / 6;
    sum  = sum - longint'(term);
    term = ((((term * x) >> 30) * x) >> 30) / 20;
    sum  = sum + longint'(term);
    term = ((((term * x) >> 30) * x) >> 30) / 42;
    sum  = sum - longint'(term);
    term = ((((term * x) >> 30) * x) >> 30) / 72;
    sum  = sum + longint'(term);
    term = ((((term * x) >> 30) * x) >> 30) / 110;
    sum  = sum - longint'(term);
    term = ((((term * x) >> 30) * x) >> 30) / 156;
    sum  = sum + longint'(term);
    term = ((((term * x) >> 30) * x) >> 30) / 210;
    sum  = sum - longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    v = ((64'(sum) * 64'd32767) + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return sine_mag_t'(v);
  endfunction

endpackage
`default_nettype wire

/* src/b2s_divider.sv */
// Restoring bit-serial divider: quotient of (d << 16) / r for d no larger than r.
`default_nettype none
module b2s_divider (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [7:0]                  dividend,
  input  wire logic [7:0]                  divisor,
  output logic                             done,
  output logic [b2s_pkg::QUOT_W-1:0]       quot
);
  import b2s_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic [7:0]        rem_r, rem_nxt;
  logic [7:0]        div_r, div_nxt;
  logic              lsb_r, lsb_nxt;
  logic [QUOT_W-1:0] quot_r, quot_nxt;
  logic [8:0]        shifted;
  logic              fits;
  logic [8:0]        diff;

  // Since d <= r, the top seven dividend bits give zero quotient bits; start from d >> 1.
  always_comb begin
    shifted = {rem_r, (cnt_r == 5'd0) ? lsb_r : 1'b0};
    fits    = shifted >= {1'b0, div_r};
    diff    = shifted - {1'b0, div_r};
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    lsb_nxt  = lsb_r;
    quot_nxt = quot_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd0;
      rem_nxt  = {1'b0, dividend[7:1]};
      lsb_nxt  = dividend[0];
      div_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt  = fits ? diff[7:0] : shifted[7:0];
      quot_nxt = {quot_r[QUOT_W-2:0], fits};
      cnt_nxt  = cnt_r + 5'd1;
      if (cnt_r == 5'(QUOT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    lsb_r  <= lsb_nxt;
    quot_r <= quot_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule
`default_nettype wire

/* src/byte_to_sample_sine_mixer_unit.sv */
// Top level: byte normalizer, sine oscillator, bit-serial blend and volume scaling.
// One item in, one signed sample out. The work runs as three bit-serial passes: the
// restoring divider that normalizes the byte, and the shared shift-add multiplier that first
// blends with the sine and then applies volume. Between and after the passes come the divider
// handoff, the sign split before the volume pass, the full-scale shift-subtract and the load
// into the output register. A new item is taken once the previous result has moved into the
// output register, even if it is not yet taken; while a waiting result is held back, the
// next item waits as well. The sine is read from a constant quarter-wave table at the phase
// held before the item, and the phase advances by phase_step on each accepted item.
`default_nettype none
module byte_to_sample_sine_mixer_unit #(
  parameter int PHASE_BITS      = 32,
  parameter int SINE_TABLE_BITS = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,     // [7:0] data_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,    // [31:0] pcm_out
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import b2s_pkg::*;

  localparam int TAB_N = 1 << SINE_TABLE_BITS;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_MIX   = 3'd2;
  localparam logic [2:0] ST_ABS   = 3'd3;
  localparam logic [2:0] ST_VOL   = 3'd4;
  localparam logic [2:0] ST_SCALE = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  localparam logic [2:0] REG_MIN    = 3'd0;
  localparam logic [2:0] REG_RANGE  = 3'd1;
  localparam logic [2:0] REG_STEP   = 3'd2;
  localparam logic [2:0] REG_SMOOTH = 3'd3;
  localparam logic [2:0] REG_VOLUME = 3'd4;
  localparam logic [2:0] REG_WIDE   = 3'd5;

  // Configuration registers
  logic [7:0]  byte_min_r;
  logic [7:0]  byte_range_r;
  logic [31:0] phase_step_r;
  logic [16:0] smooth_r;
  logic [15:0] volume_r;
  logic        wide_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_min_r   <= 8'd0;
      byte_range_r <= 8'd255;
      phase_step_r <= 32'd38654706;
      smooth_r     <= 17'd32768;
      volume_r     <= 16'd16384;
      wide_r       <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MIN:    byte_min_r   <= cfg_pwdata[7:0];
        REG_RANGE:  byte_range_r <= cfg_pwdata[7:0];
        REG_STEP:   phase_step_r <= cfg_pwdata;
        REG_SMOOTH: smooth_r     <= cfg_pwdata[16:0];
        REG_VOLUME: volume_r     <= cfg_pwdata[15:0];
        REG_WIDE:   wide_r       <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MIN:    cfg_prdata = {24'd0, byte_min_r};
      REG_RANGE:  cfg_prdata = {24'd0, byte_range_r};
      REG_STEP:   cfg_prdata = phase_step_r;
      REG_SMOOTH: cfg_prdata = {15'd0, smooth_r};
      REG_VOLUME: cfg_prdata = {16'd0, volume_r};
      REG_WIDE:   cfg_prdata = {31'd0, wide_r};
      default:    cfg_prdata = 32'd0;
    endcase
  end

  // Quarter-wave table, constant, read through a register
  sine_mag_t sine_tab [0:TAB_N];

  for (genvar k = 0; k <= TAB_N; k++) begin : g_tab
    assign sine_tab[k] = sine_entry(k, SINE_TABLE_BITS);
  end

  logic [2:0]  state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [PHASE_BITS-1:0] phase_r;
  sine_mag_t   tab_q_r;
  logic        sine_neg_r;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [ACC_W-1:0] mcand_r, mcand_nxt;
  logic [16:0] mplier_r, mplier_nxt;
  logic        neg_r, neg_nxt;
  logic [31:0] res_r, res_nxt;
  logic [31:0] out_data_r;
  logic        out_valid_r;
  logic        in_acc;
  logic        out_load;

  logic [1:0]                   quad;
  logic [SINE_TABLE_BITS-1:0]   tidx;
  logic [SINE_TABLE_BITS:0]     tsel;
  logic [7:0]                   rng;
  logic [7:0]                   d_raw;
  logic [7:0]                   d_clamp;
  logic                         div_done;
  logic [QUOT_W-1:0]            quot;
  logic signed [17:0]           norm;
  logic signed [17:0]           sine_val;
  logic signed [17:0]           diff;
  logic [16:0]                  smooth_sat;
  logic [ACC_W-1:0]             mag_full;
  logic [78:0]                  scaled_w;
  logic [62:0]                  scaled_n;
  logic [31:0]                  res_mag;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign quad = phase_r[PHASE_BITS-1 -: 2];
  assign tidx = phase_r[PHASE_BITS-3 -: SINE_TABLE_BITS];
  assign tsel = quad[0] ? ((SINE_TABLE_BITS+1)'(TAB_N) - {1'b0, tidx}) : {1'b0, tidx};

  // Clamp the byte into [min, min + range] as an offset from min; a range of 0 counts as 1
  always_comb begin
    rng     = (byte_range_r == 8'd0) ? 8'd1 : byte_range_r;
    d_raw   = (in_tdata > byte_min_r) ? (in_tdata - byte_min_r) : 8'd0;
    d_clamp = (d_raw > rng) ? rng : d_raw;
  end

  b2s_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .dividend (d_clamp),
    .divisor  (rng),
    .done     (div_done),
    .quot     (quot)
  );

  always_comb begin
    norm       = $signed({1'b0, quot}) - 18'sd32768;
    sine_val   = sine_neg_r ? -$signed({3'b000, tab_q_r}) : $signed({3'b000, tab_q_r});
    diff       = sine_val - norm;
    smooth_sat = (smooth_r > 17'(FRAC_ONE)) ? 17'(FRAC_ONE) : smooth_r;
    mag_full   = acc_r[ACC_W-1] ? (~acc_r + 48'd1) : acc_r;
    scaled_w   = {acc_r, 31'd0} - {31'd0, acc_r};
    scaled_n   = {acc_r, 15'd0} - {15'd0, acc_r};
    res_mag    = wide_r ? scaled_w[78:47] : {16'd0, scaled_n[62:47]};
  end

  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    neg_nxt    = neg_r;
    res_nxt    = res_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          // blend = n*65536 + (sine - n)*s
          acc_nxt    = {{(ACC_W-34){norm[17]}}, norm, 16'd0};
          mcand_nxt  = {{(ACC_W-18){diff[17]}}, diff};
          mplier_nxt = smooth_sat;
          cnt_nxt    = 5'd0;
          state_nxt  = ST_MIX;
        end
      end
      ST_MIX, ST_VOL: begin
        if (mplier_r[0]) begin
          acc_nxt = acc_r + mcand_r;
        end
        mcand_nxt  = {mcand_r[ACC_W-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[16:1]};
        cnt_nxt    = cnt_r + 5'd1;
        if (cnt_r == 5'd16) begin
          state_nxt = (state_r == ST_MIX) ? ST_ABS : ST_SCALE;
        end
      end
      ST_ABS: begin
        neg_nxt    = acc_r[ACC_W-1];
        acc_nxt    = '0;
        mcand_nxt  = {16'd0, mag_full[31:0]};
        mplier_nxt = {1'b0, volume_r};
        cnt_nxt    = 5'd0;
        state_nxt  = ST_VOL;
      end
      ST_SCALE: begin
        res_nxt   = neg_r ? (~res_mag + 32'd1) : res_mag;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= 5'd0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (in_acc) begin
        phase_r <= phase_r + PHASE_BITS'(phase_step_r);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_acc) begin
      tab_q_r    <= sine_tab[tsel];
      sine_neg_r <= quad[1];
    end
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    neg_r    <= neg_nxt;
    res_r    <= res_nxt;
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

/* src/b2s_checker.sv */
// Port-level checks for the byte-to-sample mixer and the bind that attaches them.
`default_nettype none
module b2s_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        cfg_pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while one is in work");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result appeared too early after an item");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("configuration port stalled");

endmodule

bind byte_to_sample_sine_mixer_unit b2s_checker u_b2s_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);
`default_nettype wire

/* verif/tb_byte_to_sample_sine_mixer_unit.sv */
// Self-checking testbench for the byte-to-sample sine mixer: directed table, then random phases.
`default_nettype none
module tb_byte_to_sample_sine_mixer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBL_N    = 1024;
  localparam int HOLD_CYC = 300;
  localparam int DRAIN    = 80;

  typedef enum logic [4:0] {
    ADDR_MIN    = 5'd0,
    ADDR_RANGE  = 5'd4,
    ADDR_STEP   = 5'd8,
    ADDR_SMOOTH = 5'd12,
    ADDR_VOLUME = 5'd16,
    ADDR_WIDE   = 5'd20
  } reg_addr_e;

  typedef struct packed {
    logic [7:0]  bmin;
    logic [7:0]  brange;
    logic [31:0] step;
    logic [16:0] smooth;
    logic [15:0] vol;
    logic        wide;
  } mix_cfg_t;

  typedef struct {
    mix_cfg_t    c;
    logic [7:0]  b;
    bit          known;
    logic [31:0] want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;     // [7:0] data_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;    // [31:0] pcm_out
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  byte_to_sample_sine_mixer_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // predictor state
  int unsigned     sine_quarter[0:TBL_N];
  mix_cfg_t        cur_cfg;
  logic [31:0]     osc_acc;
  logic [31:0]     sample_q[$];

  bit              calm;
  bit              hold_req;
  int              mismatches;
  int              samples_seen;
  int              items_sent;
  int              cfg_sets;
  bit              timed_out;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("tb_byte_to_sample_sine_mixer_unit: FAIL");
    $finish;
  end

  // Q30 Taylor series through x^15, rounded to Q15
  function automatic void build_quarter_wave();
    longint unsigned x, term, v;
    longint          acc;
    for (int k = 0; k <= TBL_N; k++) begin
      x   = (longint'(k) * 64'd1686629713) >> 10;
      term = x;
      acc  = longint'(x);
      for (int j = 1; j <= 7; j++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / longint'((2 * j) * (2 * j + 1));
        if (j % 2 == 1) acc -= longint'(term);
        else acc += longint'(term);
      end
      if (acc < 0) acc = 0;
      v = (longint'(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 32767) v = 32767;
      sine_quarter[k] = int'(v);
    end
  endfunction

  // sample for one byte; reads the oscillator, then advances it
  function automatic logic [31:0] mix_sample(input logic [7:0] b);
    longint unsigned r, d, s, full, mag, prod, hi, lo, res;
    longint          n, sn, m;
    logic [1:0]      quad;
    logic [9:0]      idx;
    r = (cur_cfg.brange == 0) ? 1 : cur_cfg.brange;
    d = (b > cur_cfg.bmin) ? b - cur_cfg.bmin : 0;
    if (d > r) d = r;
    n = longint'((d << 16) / r) - 32768;
    quad = osc_acc[31:30];
    idx  = osc_acc[29:20];
    sn = quad[0] ? sine_quarter[TBL_N - idx] : sine_quarter[idx];
    if (quad[1]) sn = -sn;
    osc_acc = osc_acc + cur_cfg.step;
    s = (cur_cfg.smooth > 65536) ? 65536 : cur_cfg.smooth;
    m = n * longint'(65536 - s) + sn * longint'(s);
    full = cur_cfg.wide ? 64'd2147483647 : 64'd32767;
    mag  = (m < 0) ? longint'(-m) : longint'(m);
    prod = mag * cur_cfg.vol;
    hi   = prod >> 24;
    lo   = prod & 64'hFFFFFF;
    res  = (hi * full + ((lo * full) >> 24)) >> 23;
    if (m < 0) res = -res;
    return res[31:0];
  endfunction

  task automatic apb_write(input reg_addr_e a, input logic [31:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= a;
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // drain, let the pipeline settle, then write every register
  task automatic load_cfg(input mix_cfg_t c);
    while (sample_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    apb_write(ADDR_MIN, 32'(c.bmin));
    apb_write(ADDR_RANGE, 32'(c.brange));
    apb_write(ADDR_STEP, c.step);
    apb_write(ADDR_SMOOTH, 32'(c.smooth));
    apb_write(ADDR_VOLUME, 32'(c.vol));
    apb_write(ADDR_WIDE, 32'(c.wide));
    cur_cfg = c;
    cfg_sets++;
  endtask

  task automatic send_byte(input logic [7:0] b, input bit known, input logic [31:0] want);
    logic [31:0] got;
    while (!calm && $urandom_range(99) < 36) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    got = mix_sample(b);
    sample_q.push_back(known ? want : got);
    items_sent++;
  endtask

  function automatic logic [31:0] pick32(input logic [31:0] hi_v);
    case ($urandom_range(5))
      0: return 0;
      1: return hi_v;
      default: return $urandom_range(hi_v);
    endcase
  endfunction

  function automatic mix_cfg_t rand_cfg();
    mix_cfg_t c;
    c.bmin   = 8'(pick32(255));
    c.brange = 8'(pick32(255));
    c.step   = ($urandom_range(3) == 0) ? 32'hFFFFFFFF : $urandom;
    c.smooth = ($urandom_range(5) == 0) ? 17'h1FFFF : 17'(pick32(65536));
    c.vol    = 16'(pick32(65535));
    c.wide   = 1'($urandom_range(1));
    return c;
  endfunction

  function automatic logic [7:0] rand_byte();
    int unsigned lo_b, hi_b;
    lo_b = cur_cfg.bmin;
    hi_b = cur_cfg.bmin + cur_cfg.brange;
    if (hi_b > 255) hi_b = 255;
    case ($urandom_range(9))
      0: return 8'(lo_b);
      1: return 8'(hi_b);
      2: return 8'($urandom_range(255));
      default: return 8'($urandom_range(hi_b, lo_b));
    endcase
  endfunction

  // receiver: random backpressure, a long hold-off on request
  initial begin
    int hold_left;
    hold_left  = 0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYC;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 36);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      samples_seen++;
      if (sample_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected sample %0d", $signed(out_tdata));
      end else begin
        logic [31:0] exp_v;
        exp_v = sample_q.pop_front();
        if (exp_v !== out_tdata) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pcm sample mismatch: expected %0d got %0d",
                     $signed(exp_v), $signed(out_tdata));
        end
      end
    end
  end

  initial begin
    localparam mix_cfg_t RST_CFG = '{8'd0, 8'd255, 32'd38654706, 17'd32768, 16'd16384, 1'b1};
    localparam mix_cfg_t MUTE    = '{8'd0, 8'd255, 32'd0, 17'd0, 16'd0, 1'b1};
    localparam mix_cfg_t CLAMP   = '{8'd100, 8'd10, 32'd0, 17'd0, 16'd65535, 1'b0};
    localparam mix_cfg_t ZRANGE  = '{8'd10, 8'd0, 32'd0, 17'd0, 16'd65535, 1'b0};
    localparam mix_cfg_t FULLW   = '{8'd0, 8'd255, 32'd0, 17'd0, 16'd65535, 1'b1};
    localparam mix_cfg_t SINESAT = '{8'd0, 8'd255, 32'hFFFFFFFF, 17'h1FFFF, 16'd65535, 1'b1};
    localparam mix_cfg_t QWALK   = '{8'd255, 8'd255, 32'h40000000, 17'd65536, 16'd64880, 1'b0};
    localparam mix_cfg_t MIXED   = '{8'd3, 8'd200, 32'd123456789, 17'd12345, 16'd40000, 1'b1};
    stim_row_t rows[$];
    mix_cfg_t  rc;
    int        n_items;

    rows = '{
      '{RST_CFG, 8'd0, 0, 0}, '{RST_CFG, 8'd255, 0, 0}, '{RST_CFG, 8'd128, 0, 0},
      '{MUTE, 8'd255, 1, 0}, '{MUTE, 8'd0, 1, 0},
      '{CLAMP, 8'd50, 1, -32'sd32766}, '{CLAMP, 8'd200, 1, 32'sd32766},
      '{CLAMP, 8'd100, 1, -32'sd32766}, '{CLAMP, 8'd110, 1, 32'sd32766},
      '{ZRANGE, 8'd11, 1, 32'sd32766}, '{ZRANGE, 8'd10, 1, -32'sd32766},
      '{ZRANGE, 8'd9, 1, -32'sd32766},
      '{FULLW, 8'd255, 1, 32'sd2147450879}, '{FULLW, 8'd0, 1, -32'sd2147450879},
      '{SINESAT, 8'd0, 0, 0}, '{SINESAT, 8'd255, 0, 0}, '{SINESAT, 8'd7, 0, 0},
      '{QWALK, 8'd0, 0, 0}, '{QWALK, 8'd255, 0, 0}, '{QWALK, 8'd128, 0, 0},
      '{QWALK, 8'd77, 0, 0},
      '{MIXED, 8'd1, 0, 0}, '{MIXED, 8'd203, 0, 0}, '{MIXED, 8'd150, 0, 0}
    };

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    mismatches  = 0;
    samples_seen = 0;
    items_sent  = 0;
    cfg_sets    = 0;
    timed_out   = 1'b0;
    build_quarter_wave();
    cur_cfg = RST_CFG;
    osc_acc = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].c != cur_cfg || (i > 0 && rows[i].c != rows[i-1].c)) begin
        in_tvalid <= 1'b0;
        load_cfg(rows[i].c);
      end
      send_byte(rows[i].b, rows[i].known, rows[i].want);
    end

    for (int ph = 0; ph < 10; ph++) begin
      in_tvalid <= 1'b0;
      calm = (ph == 3);
      if (ph == 0) rc = '{8'd255, 8'd255, 32'hFFFFFFFF, 17'd65536, 16'd65535, 1'b1};
      else if (ph == 9) rc = '{8'd0, 8'd1, 32'd1, 17'd0, 16'd64880, 1'b0};
      else rc = rand_cfg();
      load_cfg(rc);
      if (ph == 5) hold_req = 1'b1;
      n_items = 78;
      for (int k = 0; k < n_items; k++) send_byte(rand_byte(), 0, 0);
    end
    in_tvalid <= 1'b0;
    calm = 1'b0;

    fork
      begin
        while (sample_q.size() != 0) @(posedge clk);
      end
      begin
        repeat (20000) @(posedge clk);
        timed_out = 1'b1;
      end
    join_any
    disable fork;
    repeat (DRAIN) @(posedge clk);

    if (sample_q.size() != 0) begin
      mismatches++;
      $display("%0d expected samples never arrived", sample_q.size());
    end
    $display("Run covered %0d bytes over %0d register settings, %0d samples checked.",
             items_sent, cfg_sets, samples_seen);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0 && !timed_out) begin
      $display("tb_byte_to_sample_sine_mixer_unit: PASS");
    end else begin
      $display("tb_byte_to_sample_sine_mixer_unit: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* sim.f */
src/b2s_pkg.sv
src/b2s_divider.sv
src/byte_to_sample_sine_mixer_unit.sv
src/b2s_checker.sv
verif/tb_byte_to_sample_sine_mixer_unit.sv
